// ===== hw/rtl/tdda_pkg.sv =====
// ----------------------------------------------------------------------------
// tdda_pkg
// Shared types and constants for the table driven automaton acceptor.
// ----------------------------------------------------------------------------
package tdda_pkg;

  // Lanes, one per possible start state
  localparam int STATE_COUNT_MAX = 16;
  // Entries in the transition list
  localparam int TABLE_DEPTH     = 128;

  localparam int STATE_W = 4;
  localparam int SYM_W   = 8;
  localparam int ENTRY_W = 2 * STATE_W + SYM_W;
  localparam int NUM_W   = 5;
  localparam int CFG_W   = 16;
  localparam int CIDX_W  = 2;
  localparam int MASK_W  = 16;
  localparam int ECNT_W  = 8;
  localparam int COUNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int ADDR_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  typedef enum logic [1:0] {
    FUNC_LOAD   = 2'd0,
    FUNC_CLEAR  = 2'd1,
    FUNC_BEGIN  = 2'd2,
    FUNC_SYMBOL = 2'd3
  } func_t;

  typedef enum logic [CIDX_W-1:0] {
    CFG_NUM_STATES  = 2'd0,
    CFG_START_STATE = 2'd1,
    CFG_FINAL_MASK  = 2'd2,
    CFG_UNUSED      = 2'd3
  } cfg_idx_t;

  // Controller to datapath
  typedef struct packed {
    logic take;      // latch the accepted beat
    logic exec;      // apply load / clear / begin, or arm a scan
    logic scan_rd;   // read list entry at the scan pointer
    logic finish;    // kill lanes that found no match
    logic load_out;  // capture the report into the output register
  } tdda_cmd_t;

  // Datapath to controller
  typedef struct packed {
    func_t func;
    logic  count_zero;
    logic  scan_last;
  } tdda_stat_t;

endpackage

// ===== hw/rtl/tdda_dpath.sv =====
// ----------------------------------------------------------------------------
// tdda_dpath
// Transition list memory, lane registers, config registers and result beat.
// ----------------------------------------------------------------------------
module tdda_dpath (
  input  logic                                   clk,
  input  logic                                   rst,
  input  tdda_pkg::tdda_cmd_t                    cmd,
  output tdda_pkg::tdda_stat_t                   stat,
  input  logic [1:0]                             in_func,
  input  logic [tdda_pkg::STATE_W-1:0]           in_from,
  input  logic [tdda_pkg::SYM_W-1:0]             in_sym,
  input  logic [tdda_pkg::STATE_W-1:0]           in_to,
  input  logic                                   cfg_we,
  input  logic [tdda_pkg::CIDX_W-1:0]            cfg_index,
  input  logic [tdda_pkg::CFG_W-1:0]             cfg_data,
  output logic                                   out_status,
  output logic                                   out_accepted,
  output logic [tdda_pkg::MASK_W-1:0]            out_reach,
  output logic [tdda_pkg::ECNT_W-1:0]            out_count
);

  localparam int LANES = tdda_pkg::STATE_COUNT_MAX;

  // config registers
  logic [tdda_pkg::NUM_W-1:0]   num_states;
  logic [tdda_pkg::STATE_W-1:0] start_state;
  logic [tdda_pkg::MASK_W-1:0]  final_mask;

  // latched item
  tdda_pkg::func_t              func_r;
  logic [tdda_pkg::STATE_W-1:0] from_r;
  logic [tdda_pkg::SYM_W-1:0]   sym_r;
  logic [tdda_pkg::STATE_W-1:0] to_r;

  logic [tdda_pkg::ENTRY_W-1:0] mem [tdda_pkg::TABLE_DEPTH];
  logic [tdda_pkg::ENTRY_W-1:0] rd_data;
  logic                         rd_vld;
  logic [tdda_pkg::COUNT_W-1:0] count;
  logic [tdda_pkg::COUNT_W-1:0] ptr;
  logic                         status_r;

  logic [tdda_pkg::STATE_W-1:0] lane_state [LANES];
  logic [LANES-1:0]             alive;
  logic [LANES-1:0]             hit;

  logic [LANES-1:0]             lane_mask;
  logic [tdda_pkg::MASK_W-1:0]  reach;
  logic                         full;

  assign full = (count == tdda_pkg::COUNT_W'(tdda_pkg::TABLE_DEPTH));

  assign stat.func       = func_r;
  assign stat.count_zero = (count == '0);
  assign stat.scan_last  = ((ptr + tdda_pkg::COUNT_W'(1)) == count);

  always_ff @(posedge clk) begin
    if (rst) begin
      num_states  <= tdda_pkg::NUM_W'(16);
      start_state <= '0;
      final_mask  <= '0;
    end else if (cfg_we) begin
      unique case (tdda_pkg::cfg_idx_t'(cfg_index))
        tdda_pkg::CFG_NUM_STATES:  num_states  <= cfg_data[tdda_pkg::NUM_W-1:0];
        tdda_pkg::CFG_START_STATE: start_state <= cfg_data[tdda_pkg::STATE_W-1:0];
        tdda_pkg::CFG_FINAL_MASK:  final_mask  <= cfg_data[tdda_pkg::MASK_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      func_r <= tdda_pkg::func_t'(in_func);
      from_r <= in_from;
      sym_r  <= in_sym;
      to_r   <= in_to;
    end
  end

  // list memory: one write port at the fill count, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.exec && func_r == tdda_pkg::FUNC_LOAD && !full) begin
      mem[count[tdda_pkg::ADDR_W-1:0]] <= {from_r, sym_r, to_r};
    end
    if (cmd.scan_rd) begin
      rd_data <= mem[ptr[tdda_pkg::ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      ptr      <= '0;
      rd_vld   <= 1'b0;
      status_r <= 1'b0;
    end else begin
      rd_vld <= cmd.scan_rd;
      if (cmd.scan_rd) begin
        ptr <= ptr + tdda_pkg::COUNT_W'(1);
      end
      if (cmd.exec) begin
        ptr      <= '0;
        status_r <= (func_r == tdda_pkg::FUNC_LOAD) && full;
        if (func_r == tdda_pkg::FUNC_LOAD && !full) begin
          count <= count + tdda_pkg::COUNT_W'(1);
        end else if (func_r == tdda_pkg::FUNC_CLEAR) begin
          count <= '0;
        end
      end
    end
  end

  // lanes: every alive lane without a hit yet compares against the entry
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LANES; i++) begin
        lane_state[i] <= '0;
      end
      alive <= '0;
      hit   <= '0;
    end else if (cmd.exec && func_r == tdda_pkg::FUNC_BEGIN) begin
      for (int i = 0; i < LANES; i++) begin
        lane_state[i] <= tdda_pkg::STATE_W'(i);
        alive[i]      <= (i < int'(num_states));
      end
      hit <= '0;
    end else if (cmd.exec && func_r == tdda_pkg::FUNC_SYMBOL) begin
      hit <= '0;
    end else if (cmd.finish) begin
      alive <= alive & hit;
    end else if (rd_vld) begin
      for (int i = 0; i < LANES; i++) begin
        if (alive[i] && !hit[i]
            && rd_data[tdda_pkg::ENTRY_W-1 -: tdda_pkg::STATE_W] == lane_state[i]
            && rd_data[tdda_pkg::STATE_W +: tdda_pkg::SYM_W] == sym_r) begin
          lane_state[i] <= rd_data[tdda_pkg::STATE_W-1:0];
          hit[i]        <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      lane_mask[i] = alive[i] && (i < int'(num_states)) && final_mask[lane_state[i]];
    end
  end

  assign reach = tdda_pkg::MASK_W'(lane_mask);

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_status   <= status_r;
      out_accepted <= reach[start_state];
      out_reach    <= reach;
      out_count    <= tdda_pkg::ECNT_W'(count);
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= tdda_pkg::COUNT_W'(tdda_pkg::TABLE_DEPTH))
    else $error("fill count beyond list depth");

  a_hit_alive: assert property (@(posedge clk) disable iff (rst)
    (hit & ~alive) == '0)
    else $error("hit recorded on a dead lane");
`endif

endmodule

// ===== hw/rtl/tdda_ctrl.sv =====
// ----------------------------------------------------------------------------
// tdda_ctrl
// Item sequencer: accept, execute, list scan, lane retire, result hand-off.
// ----------------------------------------------------------------------------
module tdda_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  tdda_pkg::tdda_stat_t stat,
  output tdda_pkg::tdda_cmd_t  cmd
);

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_EXEC   = 6'b000010,
    ST_SCAN   = 6'b000100,
    ST_DRAIN  = 6'b001000,
    ST_FINISH = 6'b010000,
    ST_RESULT = 6'b100000
  } state_t;

  state_t state, state_next;
  logic   out_free;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == ST_IDLE);

  always_comb begin
    state_next   = state;
    cmd          = '0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.take   = 1'b1;
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.exec = 1'b1;
        if (stat.func == tdda_pkg::FUNC_SYMBOL) begin
          state_next = stat.count_zero ? ST_FINISH : ST_SCAN;
        end else begin
          state_next = ST_RESULT;
        end
      end
      ST_SCAN: begin
        cmd.scan_rd = 1'b1;
        if (stat.scan_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        cmd.finish = 1'b1;
        state_next = ST_RESULT;
      end
      ST_RESULT: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_take_exec: assert property (@(posedge clk) disable iff (rst)
    cmd.take |=> state == ST_EXEC)
    else $error("accepted beat not executed");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!out_valid || out_ready))
    else $error("result register overwritten");
`endif

endmodule

// ===== hw/rtl/table_driven_dfa_acceptor.sv =====
// ----------------------------------------------------------------------------
// table_driven_dfa_acceptor
// Programmable deterministic automaton with one lane per start state.
//
// Each input beat returns exactly one result beat. Load, clear and begin-word
// beats go from execute straight to the result state. A symbol beat scans the
// stored transition list once through the single read port of the list
// memory, one entry per cycle, all lanes matching in parallel, then waits for
// the last read and retires lanes with no match; an empty list skips the scan.
// One beat is in work at a time; a new beat is taken once the previous result
// is in the output register, even while that result still waits downstream.
// Config writes are taken on any cycle but must only be issued while the block
// is idle. The list memory has no reset; only entries below the fill count are
// ever read.
// ----------------------------------------------------------------------------
module table_driven_dfa_acceptor (
  input  logic                              clk,
  input  logic                              rst,
  // slave side
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [15:0]                       s_tdata,  // src_state[3:0], symbol_code[11:4],
                                                      // to_state[15:12]
  input  logic [1:0]                        s_tuser,  // func[1:0]
  // master side
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [31:0]                       m_tdata,  // accepted[0], reach_mask[16:1],
                                                      // entry_count[24:17], zero[31:25]
  output logic [0:0]                        m_tuser,  // status[0]
  // config write port
  input  logic                              cfg_we,
  input  logic [tdda_pkg::CIDX_W-1:0]       cfg_index,
  input  logic [tdda_pkg::CFG_W-1:0]        cfg_data
);

  tdda_pkg::tdda_cmd_t  cmd;
  tdda_pkg::tdda_stat_t stat;

  logic                          out_status;
  logic                          out_accepted;
  logic [tdda_pkg::MASK_W-1:0]   out_reach;
  logic [tdda_pkg::ECNT_W-1:0]   out_count;

  // sequencer: owns the handshakes and steps the datapath
  tdda_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // list memory, lanes, config and the result register
  tdda_dpath u_dpath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .in_func      (s_tuser),
    .in_from      (s_tdata[3:0]),
    .in_sym       (s_tdata[11:4]),
    .in_to        (s_tdata[15:12]),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .out_status   (out_status),
    .out_accepted (out_accepted),
    .out_reach    (out_reach),
    .out_count    (out_count)
  );

  assign m_tdata = {7'd0, out_count, out_reach, out_accepted};
  assign m_tuser = out_status;

endmodule
